[hdl/drp_pkg.sv]
`default_nettype none

package drp_pkg;

  localparam int unsigned PosW            = 11;
  localparam int unsigned MaxMessageBytes = 1024;

  localparam logic [7:0] OpReply      = 8'd2;
  localparam logic [7:0] OptMsgType   = 8'd53;
  localparam logic [7:0] OptPad       = 8'd0;
  localparam logic [7:0] OptEnd       = 8'hff;
  localparam logic [7:0] KindOffer    = 8'd2;
  localparam logic [7:0] KindAck      = 8'd5;

  localparam logic [PosW-1:0] PosOp          = 11'd0;
  localparam logic [PosW-1:0] PosYiaddrFirst = 11'd16;
  localparam logic [PosW-1:0] PosYiaddrLast  = 11'd19;
  localparam logic [PosW-1:0] PosOptions     = 11'd240;

  localparam logic [1:0] PhType  = 2'd0;
  localparam logic [1:0] PhLen   = 2'd1;
  localparam logic [1:0] PhValue = 2'd2;
  localparam logic [1:0] PhDone  = 2'd3;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActRequest = 2'd1,
    ActAcquire = 2'd2
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [31:0] offered_address;
    logic [31:0] host_address;
    logic        address_valid;
  } result_t;

endpackage

`default_nettype wire

[hdl/drp_if.sv]
`default_nettype none

interface drp_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] offered_address;
  logic [31:0] host_address;
  logic        address_valid;

  modport source (output valid, output action, output offered_address,
                  output host_address, output address_valid, input ready);
  modport sink   (input valid, input action, input offered_address,
                  input host_address, input address_valid, output ready);
endinterface

`default_nettype wire

[hdl/drp_parse.sv]
`default_nettype none

module drp_parse import drp_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = MaxMessageBytes
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output result_t         result_o
);

  localparam logic [PosW-1:0] PosLimit = PosW'(MAX_MESSAGE_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic            reply_q, reply_d;
  logic [31:0]     offer_q, offer_d;
  logic [1:0]      phase_q, phase_d;
  logic [7:0]      rem_q, rem_d;
  logic            in_type_q, in_type_d;
  logic [7:0]      kind_q, kind_d;
  logic            found_q, found_d;
  logic [31:0]     lease_addr_q, lease_addr_d;
  logic            lease_valid_q, lease_valid_d;
  logic [7:0]      rem_dec;
  action_e         action;

  assign rem_dec = rem_q - 8'd1;

  always_comb begin
    pos_d         = pos_q;
    reply_d       = reply_q;
    offer_d       = offer_q;
    phase_d       = phase_q;
    rem_d         = rem_q;
    in_type_d     = in_type_q;
    kind_d        = kind_q;
    found_d       = found_q;
    lease_addr_d  = lease_addr_q;
    lease_valid_d = lease_valid_q;
    action        = ActNone;

    if (pos_q < PosLimit) begin
      pos_d = pos_q + 1'b1;
      if (pos_q == PosOp) begin
        reply_d = (data_byte_i == OpReply);
      end else if (pos_q >= PosYiaddrFirst && pos_q <= PosYiaddrLast) begin
        offer_d = {offer_q[23:0], data_byte_i};
      end else if (pos_q >= PosOptions) begin
        unique case (phase_q)
          PhType: begin
            if (data_byte_i == OptEnd) begin
              phase_d = PhDone;
            end else if (data_byte_i != OptPad) begin
              in_type_d = (data_byte_i == OptMsgType) && !found_q;
              phase_d   = PhLen;
            end
          end
          PhLen: begin
            rem_d   = data_byte_i;
            phase_d = (data_byte_i == 8'd0) ? PhType : PhValue;
          end
          PhValue: begin
            if (in_type_q) begin
              kind_d    = data_byte_i;
              found_d   = 1'b1;
              in_type_d = 1'b0;
            end
            rem_d = rem_dec;
            if (rem_dec == 8'd0) begin
              phase_d = PhType;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (last_byte_i && reply_d && found_d) begin
      if (kind_d == KindOffer) begin
        action = ActRequest;
      end else if (kind_d == KindAck) begin
        lease_addr_d  = offer_d;
        lease_valid_d = 1'b1;
        action        = ActAcquire;
      end
    end

    result_o.action          = action;
    result_o.offered_address = offer_d;
    result_o.host_address    = lease_addr_d;
    result_o.address_valid   = lease_valid_d;

    // The message is over; only the lease survives it.
    if (last_byte_i) begin
      pos_d     = '0;
      reply_d   = 1'b0;
      offer_d   = '0;
      phase_d   = PhType;
      rem_d     = '0;
      in_type_d = 1'b0;
      kind_d    = '0;
      found_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      reply_q       <= 1'b0;
      offer_q       <= '0;
      phase_q       <= PhType;
      rem_q         <= '0;
      in_type_q     <= 1'b0;
      kind_q        <= '0;
      found_q       <= 1'b0;
      lease_addr_q  <= '0;
      lease_valid_q <= 1'b0;
    end else if (step_i) begin
      pos_q         <= pos_d;
      reply_q       <= reply_d;
      offer_q       <= offer_d;
      phase_q       <= phase_d;
      rem_q         <= rem_d;
      in_type_q     <= in_type_d;
      kind_q        <= kind_d;
      found_q       <= found_d;
      lease_addr_q  <= lease_addr_d;
      lease_valid_q <= lease_valid_d;
    end
  end

endmodule

`default_nettype wire

[hdl/dhcp_reply_handler.sv]
// Receive-side DHCP client logic. The block takes a message one byte per request on req_i,
// with last_byte marking the final byte, and produces one result on res_o for each message:
// action 1 asks for a request of the offered address, action 2 reports that an acknowledge
// stored the offered address as the host address, and 0 means no action. A byte passes
// through an input register and a single update of the parse state, so the block sustains
// one byte per cycle; the result of a final byte is written to the output register, where it
// is held until res_o.ready takes it. Only a final byte whose result finds the output
// register still occupied holds the input back.
`default_nettype none

module dhcp_reply_handler import drp_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = MaxMessageBytes
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  drp_req_if.sink   req_i,
  drp_res_if.source res_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    res_next;
  logic       out_free;
  logic       step;
  logic       accept;

  assign out_free    = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && (!in_last_q || out_free);
  assign req_i.ready = !in_valid_q || step;
  assign accept      = req_i.valid && req_i.ready;

  drp_parse #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .data_byte_i(in_byte_q),
    .last_byte_i(in_last_q),
    .result_o   (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= req_i.data_byte;
      in_last_q <= req_i.last_byte;
    end
    if (step && in_last_q) begin
      out_res_q <= res_next;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.action          = out_res_q.action;
  assign res_o.offered_address = out_res_q.offered_address;
  assign res_o.host_address    = out_res_q.host_address;
  assign res_o.address_valid   = out_res_q.address_valid;

endmodule

`default_nettype wire

[hdl/drp_checker.sv]
`default_nettype none

module drp_checker import drp_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic [1:0]  action_i,
  input wire logic [31:0] offered_address_i,
  input wire logic [31:0] host_address_i,
  input wire logic        address_valid_i
);

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(action_i)
      && $stable(host_address_i) && $stable(address_valid_i))
    else $error("result changed while stalled");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> action_i == ActNone || action_i == ActRequest || action_i == ActAcquire)
    else $error("undefined action code");

  a_acquire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && action_i == ActAcquire |-> address_valid_i)
    else $error("acquired lease not marked valid");

  a_acquire_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && action_i == ActAcquire |-> host_address_i == offered_address_i)
    else $error("acquired lease does not hold offered address");

endmodule

bind dhcp_reply_handler drp_checker u_drp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .action_i         (res_o.action),
  .offered_address_i(res_o.offered_address),
  .host_address_i   (res_o.host_address),
  .address_valid_i  (res_o.address_valid)
);

`default_nettype wire

[verif/dhcp_reply_handler_tb.sv]
`default_nettype none

module dhcp_reply_handler_tb;
  import drp_pkg::*;

  typedef logic [7:0] byte_q [$];

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxPrinted = 50;

  logic clk_i;
  logic rst_ni;

  drp_req_if req_if ();
  drp_res_if res_if ();

  dhcp_reply_handler dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned ready_hold_left;

  result_t expected_results [$];

  // Parse state of the current message and the stored lease.
  logic [PosW-1:0] msg_pos;
  logic            op_is_reply;
  logic [31:0]     yiaddr_shift;
  logic [1:0]      walk_phase;
  logic [7:0]      value_left;
  logic            taking_kind;
  logic [7:0]      msg_kind;
  logic            kind_taken;
  logic [31:0]     host_addr;
  logic            host_valid;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  function automatic void clear_message();
    msg_pos      = '0;
    op_is_reply  = 1'b0;
    yiaddr_shift = '0;
    walk_phase   = PhType;
    value_left   = '0;
    taking_kind  = 1'b0;
    msg_kind     = '0;
    kind_taken   = 1'b0;
  endfunction

  function automatic void walk_options(input logic [7:0] b);
    case (walk_phase)
      PhType: begin
        if (b == OptEnd) begin
          walk_phase = PhDone;
        end else if (b != OptPad) begin
          taking_kind = (b == OptMsgType) && !kind_taken;
          walk_phase  = PhLen;
        end
      end
      PhLen: begin
        value_left = b;
        walk_phase = (b == 8'd0) ? PhType : PhValue;
      end
      PhValue: begin
        if (taking_kind) begin
          msg_kind    = b;
          kind_taken  = 1'b1;
          taking_kind = 1'b0;
        end
        value_left = value_left - 8'd1;
        if (value_left == 8'd0) begin
          walk_phase = PhType;
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (msg_pos < MaxMessageBytes) begin
      if (msg_pos == PosOp) begin
        op_is_reply = (b == OpReply);
      end else if (msg_pos >= PosYiaddrFirst && msg_pos <= PosYiaddrLast) begin
        yiaddr_shift = {yiaddr_shift[23:0], b};
      end else if (msg_pos >= PosOptions) begin
        walk_options(b);
      end
      msg_pos = msg_pos + 1'b1;
    end
    if (last) begin
      r.action = ActNone;
      if (op_is_reply && kind_taken) begin
        if (msg_kind == KindOffer) begin
          r.action = ActRequest;
        end else if (msg_kind == KindAck) begin
          host_addr  = yiaddr_shift;
          host_valid = 1'b1;
          r.action   = ActAcquire;
        end
      end
      r.offered_address = yiaddr_shift;
      r.host_address    = host_addr;
      r.address_valid   = host_valid;
      expected_results.push_back(r);
      clear_message();
    end
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold_left > 0) begin
      ready_hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected, action %0d",
                                  res_if.action));
      end else begin
        want = expected_results.pop_front();
        if (res_if.action !== want.action) begin
          report_mismatch($sformatf("action %0d, expected %0d",
                                    res_if.action, want.action));
        end
        if (res_if.offered_address !== want.offered_address) begin
          report_mismatch($sformatf("offered address %h, expected %h",
                                    res_if.offered_address, want.offered_address));
        end
        if (res_if.host_address !== want.host_address) begin
          report_mismatch($sformatf("host address %h, expected %h",
                                    res_if.host_address, want.host_address));
        end
        if (res_if.address_valid !== want.address_valid) begin
          report_mismatch($sformatf("address valid %b, expected %b",
                                    res_if.address_valid, want.address_valid));
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= b;
    req_if.last_byte <= last;
    do @(posedge clk_i); while (!req_if.ready);
    absorb_byte(b, last);
  endtask

  task automatic send_message(input byte_q m);
    foreach (m[k]) begin
      send_byte(m[k], k == m.size() - 1);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic byte_q dhcp_header(input logic [7:0] op, input logic [31:0] addr);
    byte_q m;
    m.push_back(op);
    for (int p = 1; p < int'(PosOptions); p++) begin
      if (p >= int'(PosYiaddrFirst) && p <= int'(PosYiaddrLast)) begin
        m.push_back(addr[8*(int'(PosYiaddrLast) - p) +: 8]);
      end else begin
        m.push_back(8'($urandom_range(255)));
      end
    end
    return m;
  endfunction

  function automatic byte_q random_message();
    byte_q m;
    int unsigned n_opt;
    int unsigned len;
    int unsigned pick;
    logic [7:0] op;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(300, 1);
      repeat (len) m.push_back(8'($urandom_range(255)));
      return m;
    end
    op = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : OpReply;
    m = dhcp_header(op, $urandom);
    n_opt = $urandom_range(6);
    repeat (n_opt) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        m.push_back(OptPad);
      end else if (pick < 5) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(3) : 1;
        m.push_back(OptMsgType);
        m.push_back(8'(len));
        repeat (len) begin
          if ($urandom_range(2) == 0) begin
            m.push_back(8'($urandom_range(255)));
          end else begin
            m.push_back(($urandom_range(1) == 0) ? KindOffer : KindAck);
          end
        end
      end else begin
        len = $urandom_range(6);
        m.push_back(8'($urandom_range(254, 1)));
        m.push_back(8'(len));
        repeat (len) m.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(4) != 0) begin
      m.push_back(OptEnd);
    end
    repeat ($urandom_range(3)) m.push_back(8'($urandom_range(255)));
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(m.size(), 1);
      while (m.size() > len) begin
        void'(m.pop_back());
      end
    end
    return m;
  endfunction

  task automatic test_directed();
    byte_q m;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    m = dhcp_header(OpReply, 32'hc0a8_0164);
    send_message({m, OptMsgType, 8'd1, KindOffer, OptEnd});
    m = dhcp_header(OpReply, 32'hffff_ffff);
    send_message({m, OptPad, OptPad, OptMsgType, 8'd1, KindAck, OptEnd});
    m = dhcp_header(8'd1, 32'h0a00_0001);
    send_message({m, OptMsgType, 8'd1, KindAck, OptEnd});
    m = dhcp_header(OpReply, 32'h0000_0000);
    send_message({m, OptMsgType, 8'd1, KindAck});
    m = dhcp_header(OpReply, $urandom);
    send_message({m, 8'd1, 8'd4, 8'h00, 8'hff, 8'h5a, 8'ha5, OptEnd});
    m = dhcp_header(OpReply, $urandom);
    send_message({m, OptMsgType, 8'd0, OptMsgType, 8'd1, KindOffer, OptEnd});
    m = dhcp_header(OpReply, 32'h1234_5678);
    send_message({m, OptMsgType, 8'd2, KindAck, KindOffer, OptMsgType, 8'd1, KindOffer,
                  OptEnd});
    m = dhcp_header(OpReply, $urandom);
    send_message({m, OptEnd, OptMsgType, 8'd1, KindAck});
    m = dhcp_header(OpReply, $urandom);
    send_message({m, OptMsgType, 8'd1, 8'd3, OptEnd});
    m = dhcp_header(OpReply, $urandom);
    send_message({m, OptMsgType, 8'd1, 8'hff, OptEnd});

    // An option value that is 255 bytes long hides option-like bytes.
    m = dhcp_header(OpReply, $urandom);
    m = {m, 8'd12, 8'd255};
    repeat (255) m.push_back(($urandom_range(1) == 0) ? OptMsgType : KindAck);
    send_message({m, OptMsgType, 8'd1, KindOffer, OptEnd});

    send_message({OpReply});
    send_message({8'hff});
    send_message({8'h00, 8'h00});
    m = dhcp_header(OpReply, 32'h89ab_cdef);
    while (m.size() > 18) begin
      void'(m.pop_back());
    end
    send_message(m);
    m = dhcp_header(OpReply, $urandom);
    send_message({m, OptMsgType});

    // Options past the first MaxMessageBytes bytes of a message are ignored.
    m = dhcp_header(OpReply, $urandom);
    while (m.size() < MaxMessageBytes) begin
      m.push_back(OptPad);
    end
    send_message({m, OptMsgType, 8'd1, KindAck, OptEnd, 8'h11, 8'h22, 8'h33});
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned send_idle,
                                     input int unsigned recv_stall);
    byte_q m;
    int unsigned byte_total;
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    byte_total = 0;
    while (byte_total < 425) begin
      m = random_message();
      send_message(m);
      byte_total += m.size();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    byte_q m;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    ready_hold_left    = 300;
    repeat (40) begin
      m = {};
      repeat ($urandom_range(3, 1)) m.push_back(8'($urandom_range(255)));
      send_message(m);
    end
    wait_drained();
  endtask

  initial begin
    cycle_count        = 0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    ready_hold_left    = 0;
    host_addr          = '0;
    host_valid         = 1'b0;
    clear_message();
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.data_byte = '0;
    req_if.last_byte = 1'b0;
    res_if.ready     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(0, 0);
    test_random_traffic(64, 0);
    test_random_traffic(0, 64);
    test_random_traffic(30, 30);
    test_backpressure();

    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
